### src/imuid_pkg.sv
package imuid_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int THR_WIDTH    = 16;
  localparam int HOLD_WIDTH   = 32;
  localparam int DIR_WIDTH    = 4;
  localparam int NUM_AXES     = 3;
  localparam int NUM_LANES    = 2 * NUM_AXES;
  localparam int LANE_IDX_W   = $clog2(NUM_LANES);
  localparam int CFG_IDX_W    = 2;

  // width at which an absolute change meets its threshold
  localparam int CMP_W = (SAMPLE_WIDTH + 1 > THR_WIDTH) ? SAMPLE_WIDTH + 1 : THR_WIDTH;
  // width at which elapsed time meets the holdoff
  localparam int HCMP_W = (TIME_WIDTH > HOLD_WIDTH) ? TIME_WIDTH : HOLD_WIDTH;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd2;

  // register reset values
  localparam logic [THR_WIDTH-1:0]  ACCEL_THR_RST = 16'd1638;
  localparam logic [THR_WIDTH-1:0]  GYRO_THR_RST  = 16'd461;
  localparam logic [HOLD_WIDTH-1:0] HOLDOFF_RST   = 32'd2000;

  // direction codes
  localparam logic [DIR_WIDTH-1:0] DIR_NONE       = 4'd0;
  localparam logic [DIR_WIDTH-1:0] DIR_ACCEL_BASE = 4'd1;
  localparam logic [DIR_WIDTH-1:0] DIR_GYRO_BASE  = 4'd7;

  typedef struct packed {
    logic hit;
    logic neg;
  } lane_res_t;

  typedef struct packed {
    logic                 impact;
    logic [DIR_WIDTH-1:0] dir;
    logic                 fire;
    logic                 first_clear;
  } merge_res_t;

  // code of the direction seen on one lane
  function automatic logic [DIR_WIDTH-1:0] dir_code(input logic [LANE_IDX_W-1:0] lane,
                                                    input logic neg);
    logic [DIR_WIDTH-1:0] base;
    logic [LANE_IDX_W-1:0] axis;
    if (lane < LANE_IDX_W'(NUM_AXES)) begin
      base = DIR_ACCEL_BASE;
      axis = lane;
    end else begin
      base = DIR_GYRO_BASE;
      axis = lane - LANE_IDX_W'(NUM_AXES);
    end
    return base + DIR_WIDTH'({axis, 1'b0}) + DIR_WIDTH'(neg);
  endfunction

endpackage

### src/imuid_lane.sv
module imuid_lane
  import imuid_pkg::*;
(
  input  logic signed [SAMPLE_WIDTH-1:0] cur,
  input  logic signed [SAMPLE_WIDTH-1:0] prev,
  input  logic        [THR_WIDTH-1:0]    thr,
  output lane_res_t                      res
);

  logic signed [SAMPLE_WIDTH:0] diff;
  logic        [SAMPLE_WIDTH:0] mag;

  assign diff = {cur[SAMPLE_WIDTH-1], cur} - {prev[SAMPLE_WIDTH-1], prev};
  // full range change fits unsigned in one extra bit
  assign mag  = diff[SAMPLE_WIDTH] ? (~diff + 1'b1) : diff;

  assign res.hit = CMP_W'(mag) > CMP_W'(thr);
  assign res.neg = diff[SAMPLE_WIDTH];

endmodule

### src/imuid_merge.sv
module imuid_merge
  import imuid_pkg::*;
(
  input  lane_res_t                      lane_res [NUM_LANES],
  input  logic                           accel_valid,
  input  logic                           gyro_valid,
  input  logic        [DIR_WIDTH-1:0]    held_dir,
  input  logic        [TIME_WIDTH-1:0]   now,
  input  logic        [TIME_WIDTH-1:0]   last_time,
  input  logic        [HOLD_WIDTH-1:0]   holdoff,
  input  logic                           first_pending,
  output merge_res_t                     res
);

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  hold_ok;

  assign elapsed = now - last_time;
  assign hold_ok = HCMP_W'(elapsed) >= HCMP_W'(holdoff);

  // later lanes override earlier ones, gyro lanes come last
  always_comb begin
    res.impact = 1'b0;
    res.dir    = held_dir;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (((i < NUM_AXES) ? accel_valid : gyro_valid) && lane_res[i].hit) begin
        res.impact = 1'b1;
        res.dir    = dir_code(LANE_IDX_W'(i), lane_res[i].neg);
      end
    end
    res.first_clear = res.impact && hold_ok && first_pending;
    res.fire        = res.impact && hold_ok && !first_pending;
  end

endmodule

### src/imu_impact_direction_detector_core.sv
// impact and direction detector for a 6-axis imu sample stream. each item carries a
// millisecond timestamp and an accel and a gyro triple with valid flags; per valid
// axis the change from the previous sample of that triple is compared against the
// triple's threshold (raw lsb: 8192 per g, 512 per dps), a strict exceedance flags an
// impact and sets the held direction, later axes win and gyro wins over accel. the
// direction output repeats the held code when nothing hit. an impact fires an action
// once the wrapped time since the last action reaches holdoff_ms, except the first
// such impact after reset, which is swallowed. one item per cycle unless the output
// stalls, result registered: six subtract/compare lanes, a priority merge and the
// holdoff compare all settle within the cycle that updates the stored samples. a
// two-entry output buffer lets the input keep flowing while a result waits.
// thresholds and holdoff are written at cfg_index 0, 1, 2; cfg_ready is always high.
module imu_impact_direction_detector_core
  import imuid_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic        [TIME_WIDTH-1:0]   in_time_ms,
  input  logic                           in_accel_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_accel_z,
  input  logic                           in_gyro_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gyro_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gyro_y,
  input  logic signed [SAMPLE_WIDTH-1:0] in_gyro_z,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_impact,
  output logic        [DIR_WIDTH-1:0]    out_direction_code,
  output logic                           out_action_fire,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [HOLD_WIDTH-1:0]   cfg_data
);

  // configuration registers
  logic [THR_WIDTH-1:0]  accel_thr_r;
  logic [THR_WIDTH-1:0]  gyro_thr_r;
  logic [HOLD_WIDTH-1:0] holdoff_r;

  // detector state
  logic signed [SAMPLE_WIDTH-1:0] prev_accel_r [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] prev_gyro_r  [NUM_AXES];
  logic        [TIME_WIDTH-1:0]   last_time_r;
  logic                           first_pending_r;
  logic        [DIR_WIDTH-1:0]    held_dir_r;

  // output buffer: main stage drives the ports, skid catches an item under stall
  logic                 out_valid_r;
  logic                 out_impact_r;
  logic [DIR_WIDTH-1:0] out_dir_r;
  logic                 out_fire_r;
  logic                 skid_valid_r;
  logic                 skid_impact_r;
  logic [DIR_WIDTH-1:0] skid_dir_r;
  logic                 skid_fire_r;

  logic signed [SAMPLE_WIDTH-1:0] cur   [NUM_LANES];
  logic signed [SAMPLE_WIDTH-1:0] prev  [NUM_LANES];
  logic        [THR_WIDTH-1:0]    thr   [NUM_LANES];
  lane_res_t                      lane_res [NUM_LANES];
  merge_res_t                     mres;

  logic in_take;
  logic out_take;
  logic cfg_take;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  assign out_valid          = out_valid_r;
  assign out_impact         = out_impact_r;
  assign out_direction_code = out_dir_r;
  assign out_action_fire    = out_fire_r;

  // lane inputs: accel x/y/z then gyro x/y/z
  assign cur[0] = in_accel_x;
  assign cur[1] = in_accel_y;
  assign cur[2] = in_accel_z;
  assign cur[3] = in_gyro_x;
  assign cur[4] = in_gyro_y;
  assign cur[5] = in_gyro_z;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      prev[i]            = prev_accel_r[i];
      prev[i + NUM_AXES] = prev_gyro_r[i];
      thr[i]             = accel_thr_r;
      thr[i + NUM_AXES]  = gyro_thr_r;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    imuid_lane u_lane (
      .cur  (cur[g]),
      .prev (prev[g]),
      .thr  (thr[g]),
      .res  (lane_res[g])
    );
  end

  imuid_merge u_merge (
    .lane_res      (lane_res),
    .accel_valid   (in_accel_valid),
    .gyro_valid    (in_gyro_valid),
    .held_dir      (held_dir_r),
    .now           (in_time_ms),
    .last_time     (last_time_r),
    .holdoff       (holdoff_r),
    .first_pending (first_pending_r),
    .res           (mres)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_thr_r <= ACCEL_THR_RST;
      gyro_thr_r  <= GYRO_THR_RST;
      holdoff_r   <= HOLDOFF_RST;
    end else if (cfg_take) begin
      case (cfg_index)
        REG_ACCEL_THR: accel_thr_r <= cfg_data[THR_WIDTH-1:0];
        REG_GYRO_THR:  gyro_thr_r  <= cfg_data[THR_WIDTH-1:0];
        REG_HOLDOFF:   holdoff_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // detector state update on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_accel_r[i] <= '0;
        prev_gyro_r[i]  <= '0;
      end
      last_time_r     <= '0;
      first_pending_r <= 1'b1;
      held_dir_r      <= DIR_NONE;
    end else if (in_take) begin
      if (in_accel_valid) begin
        for (int i = 0; i < NUM_AXES; i++) prev_accel_r[i] <= cur[i];
      end
      if (in_gyro_valid) begin
        for (int i = 0; i < NUM_AXES; i++) prev_gyro_r[i] <= cur[i + NUM_AXES];
      end
      held_dir_r <= mres.dir;
      if (mres.fire) last_time_r <= in_time_ms;
      if (mres.first_clear) first_pending_r <= 1'b0;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        out_valid_r  <= skid_valid_r || in_take;
        skid_valid_r <= 1'b0;
      end else if (in_take) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_impact_r <= skid_impact_r;
        out_dir_r    <= skid_dir_r;
        out_fire_r   <= skid_fire_r;
      end else begin
        out_impact_r <= mres.impact;
        out_dir_r    <= mres.dir;
        out_fire_r   <= mres.fire;
      end
    end else if (in_take) begin
      skid_impact_r <= mres.impact;
      skid_dir_r    <= mres.dir;
      skid_fire_r   <= mres.fire;
    end
  end

`ifndef SYNTHESIS
  // skid stage only ever holds an item behind a full main stage
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while main stage is empty");

  // a fired action always comes with an impact
  a_fire_needs_impact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_fire) |-> out_impact)
    else $error("action fired without impact");

  // no action can fire before the first impact was swallowed
  a_fire_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_fire) |-> !first_pending_r)
    else $error("action fired while first impact still pending");

  // a fired action records its timestamp
  a_fire_sets_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && mres.fire) |=> (last_time_r == $past(in_time_ms)))
    else $error("last action time not updated on fire");
`endif

endmodule
